// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL core of the responder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/tftp_rsr_pkg.sv =====
// Types and constants of the TFTP read session responder.
`default_nettype none

package tftp_rsr_pkg;

    // Full data block size in bytes.
    localparam int BLOCK_BYTES = 512;

    localparam int BYTES_W = 10;
    localparam int CMP_W   = 11;

    // Largest length a data packet may carry, limited by the byte field.
    localparam int BYTES_LIM_INT = (BLOCK_BYTES > 1023) ? 1023 : BLOCK_BYTES;
    localparam logic [BYTES_W-1:0] BYTES_LIM  = BYTES_W'(BYTES_LIM_INT);
    localparam logic [CMP_W-1:0]   BLOCK_FULL = CMP_W'(BLOCK_BYTES);

    localparam logic [15:0] OPC_RRQ = 16'd1;
    localparam logic [15:0] OPC_ACK = 16'd4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_PASS  = 2'd2;

    localparam logic [2:0] ERR_UNDEF   = 3'd0;
    localparam logic [2:0] ERR_ILLEGAL = 3'd4;

    localparam logic [1:0] RSN_NONE         = 2'd0;
    localparam logic [1:0] RSN_BAD_OPC_IDLE = 2'd1;
    localparam logic [1:0] RSN_BLK_MISMATCH = 2'd2;
    localparam logic [1:0] RSN_BAD_OPC_CK   = 2'd3;

    typedef struct packed {
        logic [15:0]        pkt_opcode;
        logic [15:0]        pkt_cookie;
        logic [15:0]        acked_block;
        logic [BYTES_W-1:0] next_block_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         response_kind;
        logic [15:0]        cookie_out;
        logic [15:0]        block_number;
        logic [BYTES_W-1:0] data_bytes;
        logic [2:0]         wire_error_code;
        logic [1:0]         error_reason;
        logic               fetch_block;
        logic               release_source;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/tftp_read_session_responder_core.sv =====
// TFTP read session responder: packet header in, one response header out.
//
//  channel | signals                          | moves
//  --------+----------------------------------+-------------------------------
//  input   | i_in_valid  o_in_ready  i_in_data | received header + block length
//  output  | o_out_valid i_out_ready o_out_data| response header per packet
//
// One transaction per cycle sustained while the output is not stalled; a packet
// passes through the input register, then the compare-and-update of the session
// state into the output register, and leaves it as its response.
// Reset (i_rst_n low, synchronous) returns the session to idle and empties both
// registers. A stalled output holds its response and stops the update stage; the
// input register takes one more transaction only if it is empty, then o_in_ready drops.
`default_nettype none

`include "assert_macros.svh"

module tftp_read_session_responder_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire tftp_rsr_pkg::t_in_item  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output tftp_rsr_pkg::t_out_item    o_out_data
);

    logic                    r_in_valid;
    tftp_rsr_pkg::t_in_item  r_in;
    logic                    r_out_valid;
    tftp_rsr_pkg::t_out_item r_out;

    logic        r_waiting_ack;
    logic [15:0] r_session_cookie;
    logic [15:0] r_current_block;
    logic        r_last_was_short;

    logic        n_waiting_ack;
    logic [15:0] n_session_cookie;
    logic [15:0] n_current_block;
    logic        n_last_was_short;
    tftp_rsr_pkg::t_out_item n_out;

    logic w_fire;
    logic [tftp_rsr_pkg::BYTES_W-1:0] w_bytes;

    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Saturate the offered block length to the block size.
    assign w_bytes = (r_in.next_block_bytes > tftp_rsr_pkg::BYTES_LIM)
                   ? tftp_rsr_pkg::BYTES_LIM : r_in.next_block_bytes;

    always_comb begin
        n_waiting_ack    = r_waiting_ack;
        n_session_cookie = r_session_cookie;
        n_current_block  = r_current_block;
        n_last_was_short = r_last_was_short;
        n_out            = '0;

        if (!r_waiting_ack) begin
            if (r_in.pkt_opcode == tftp_rsr_pkg::OPC_RRQ) begin
                n_session_cookie   = r_in.pkt_cookie;
                n_current_block    = 16'd1;
                n_last_was_short   = ({1'b0, w_bytes} < tftp_rsr_pkg::BLOCK_FULL);
                n_waiting_ack      = 1'b1;
                n_out.response_kind = tftp_rsr_pkg::KIND_DATA;
                n_out.block_number = 16'd1;
                n_out.data_bytes   = w_bytes;
                n_out.fetch_block  = 1'b1;
            end else begin
                n_out.response_kind   = tftp_rsr_pkg::KIND_ERROR;
                n_out.wire_error_code = tftp_rsr_pkg::ERR_ILLEGAL;
                n_out.error_reason    = tftp_rsr_pkg::RSN_BAD_OPC_IDLE;
            end
        end else if (r_in.pkt_opcode == tftp_rsr_pkg::OPC_ACK
                     && r_in.pkt_cookie == r_session_cookie) begin
            if (r_in.acked_block == r_current_block) begin
                if (r_last_was_short) begin
                    // Final block acknowledged: close the session.
                    n_waiting_ack        = 1'b0;
                    n_current_block      = 16'd0;
                    n_last_was_short     = 1'b0;
                    n_out.response_kind  = tftp_rsr_pkg::KIND_PASS;
                    n_out.release_source = 1'b1;
                end else begin
                    n_current_block     = r_current_block + 16'd1;
                    n_last_was_short    = ({1'b0, w_bytes} < tftp_rsr_pkg::BLOCK_FULL);
                    n_out.response_kind = tftp_rsr_pkg::KIND_DATA;
                    n_out.block_number  = r_current_block + 16'd1;
                    n_out.data_bytes    = w_bytes;
                    n_out.fetch_block   = 1'b1;
                end
            end else begin
                n_waiting_ack         = 1'b0;
                n_current_block       = 16'd0;
                n_last_was_short      = 1'b0;
                n_out.response_kind   = tftp_rsr_pkg::KIND_ERROR;
                n_out.wire_error_code = tftp_rsr_pkg::ERR_UNDEF;
                n_out.error_reason    = tftp_rsr_pkg::RSN_BLK_MISMATCH;
                n_out.release_source  = 1'b1;
            end
        end else begin
            n_waiting_ack         = 1'b0;
            n_current_block       = 16'd0;
            n_last_was_short      = 1'b0;
            n_out.response_kind   = tftp_rsr_pkg::KIND_ERROR;
            n_out.wire_error_code = tftp_rsr_pkg::ERR_ILLEGAL;
            n_out.error_reason    = tftp_rsr_pkg::RSN_BAD_OPC_CK;
            n_out.release_source  = 1'b1;
        end

        n_out.cookie_out = n_session_cookie;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_waiting_ack    <= 1'b0;
            r_session_cookie <= 16'd0;
            r_current_block  <= 16'd0;
            r_last_was_short <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid      <= 1'b1;
                r_waiting_ack    <= n_waiting_ack;
                r_session_cookie <= n_session_cookie;
                r_current_block  <= n_current_block;
                r_last_was_short <= n_last_was_short;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    `ASSERT_NXT(a_fire_loads_out, i_clk, i_rst_n, w_fire, r_out_valid, "response not registered")
    `ASSERT_NXT(a_release_idles, i_clk, i_rst_n, w_fire && n_out.release_source, !r_waiting_ack && r_current_block == 16'd0, "session not closed on release")
    `ASSERT_NXT(a_idle_bad_opc, i_clk, i_rst_n, w_fire && !r_waiting_ack && r_in.pkt_opcode != tftp_rsr_pkg::OPC_RRQ, !r_waiting_ack, "left idle without read request")
    `ASSERT_IMP(a_data_fetches, i_clk, i_rst_n, r_out_valid && r_out.response_kind == tftp_rsr_pkg::KIND_DATA, r_out.fetch_block && !r_out.release_source && r_waiting_ack, "data response without fetch")

endmodule

`default_nettype wire
